// ===== src/dhv_pkg.sv =====
// ----------------------------------------------------------------------------
// dhv_pkg
// Shared types and constants for the host name checker.
// ----------------------------------------------------------------------------
package dhv_pkg;

	localparam int unsigned CharW      = 8;
	localparam int unsigned NameLenW   = 8;
	localparam int unsigned LabelLenW  = 6;
	localparam int unsigned TotalW     = 9;
	localparam int unsigned LabelCntW  = 7;
	localparam int unsigned CfgIndexW  = 8;
	localparam int unsigned CfgDataW   = 8;

	localparam logic [NameLenW-1:0]  NAME_LIMIT_RESET  = 8'd255;
	localparam logic [LabelLenW-1:0] LABEL_LIMIT_RESET = 6'd63;
	localparam logic [LabelCntW-1:0] LABEL_SAT         = 7'd127;

	localparam logic [CharW-1:0] CHAR_HYPHEN = 8'h2D;
	localparam logic [CharW-1:0] CHAR_DOT    = 8'h2E;

	localparam logic [CfgIndexW-1:0] REG_MAX_NAME_LENGTH  = 8'd0;
	localparam logic [CfgIndexW-1:0] REG_MAX_LABEL_LENGTH = 8'd1;

	typedef struct packed {
		logic letter;
		logic digit;
		logic hyphen;
		logic dot;
	} char_class_t;

	typedef struct packed {
		logic              name_valid;
		logic [TotalW-1:0] name_length;
	} name_result_t;

endpackage

// ===== src/dns_hostname_validator.sv =====
// ----------------------------------------------------------------------------
// dns_hostname_validator
// Checks a host name streamed one character per request.
// ----------------------------------------------------------------------------
// Usage:
//   The character channel (char_valid, char_stall, character, last) carries one
//   byte of the name per request; last marks the final byte. Only the final
//   byte produces a request on the result channel (result_valid, result_stall,
//   name_valid, name_length). name_length is the byte count, saturating at 256.
//   The configuration channel (cfg_valid, cfg_ready, cfg_index, cfg_data)
//   writes max_name_length (index 0) or max_label_length (index 1); other
//   indexes are ignored. cfg_ready is always high. Write only while idle.
// Timing:
//   One byte per cycle sustained, unless a final byte waits behind a stalled
//   result. A byte sits in the input register while the rule logic runs, and
//   the verdict of a final byte is captured in the result register when that
//   byte leaves the input register; result_valid then rises.
// Reset:
//   Limits return to 255 and 63, the per-name state clears, both registers
//   empty. When the result is stalled, a final byte in the input register is
//   held and char_stall rises; no other bytes are taken meanwhile.
// ----------------------------------------------------------------------------
module dns_hostname_validator
	import dhv_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 char_valid,
	output logic                 char_stall,
	input  logic [CharW-1:0]     character,
	input  logic                 last,
	output logic                 result_valid,
	input  logic                 result_stall,
	output logic                 name_valid,
	output logic [TotalW-1:0]    name_length,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CfgIndexW-1:0] cfg_index,
	input  logic [CfgDataW-1:0]  cfg_data
);

	logic [NameLenW-1:0]  max_name_q;
	logic [LabelLenW-1:0] max_label_q;

	logic             valid_s1;
	logic [CharW-1:0] char_s1;
	logic             last_s1;

	logic             result_valid_q;
	name_result_t     result_q;

	logic             advance;
	logic             step;
	logic             char_accept;
	char_class_t      char_class;
	name_result_t     result_next;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_name_q  <= NAME_LIMIT_RESET;
			max_label_q <= LABEL_LIMIT_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_MAX_NAME_LENGTH:  max_name_q  <= cfg_data;
				REG_MAX_LABEL_LENGTH: max_label_q <= cfg_data[LabelLenW-1:0];
				default: ;
			endcase
		end
	end

	// A final byte can only leave the input register when the result slot is free.
	assign advance     = !(last_s1 && result_valid_q && result_stall);
	assign step        = valid_s1 && advance;
	assign char_stall  = valid_s1 && !advance;
	assign char_accept = char_valid && !char_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (char_accept) begin
			valid_s1 <= 1'b1;
		end else if (step) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (char_accept) begin
			char_s1 <= character;
			last_s1 <= last;
		end
	end

	dhv_classify u_classify (
		.character  (char_s1),
		.char_class (char_class)
	);

	dhv_name_check u_name_check (
		.clk              (clk),
		.arst_n           (arst_n),
		.step             (step),
		.last             (last_s1),
		.char_class       (char_class),
		.max_name_length  (max_name_q),
		.max_label_length (max_label_q),
		.result           (result_next)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (step && last_s1) begin
			result_valid_q <= 1'b1;
		end else if (!result_stall) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step && last_s1) begin
			result_q <= result_next;
		end
	end

	assign result_valid = result_valid_q;
	assign name_valid   = result_q.name_valid;
	assign name_length  = result_q.name_length;

endmodule

// ===== src/dhv_classify.sv =====
// ----------------------------------------------------------------------------
// dhv_classify
// Sorts one byte into letter, digit, hyphen or dot; any other byte sets no class.
// ----------------------------------------------------------------------------
module dhv_classify
	import dhv_pkg::*;
(
	input  logic [CharW-1:0] character,
	output char_class_t      char_class
);

	always_comb begin
		char_class.letter = ((character >= 8'h41) && (character <= 8'h5A)) ||
		                    ((character >= 8'h61) && (character <= 8'h7A));
		char_class.digit  = (character >= 8'h30) && (character <= 8'h39);
		char_class.hyphen = (character == CHAR_HYPHEN);
		char_class.dot    = (character == CHAR_DOT);
	end

endmodule

// ===== src/dhv_name_check.sv =====
// ----------------------------------------------------------------------------
// dhv_name_check
// Per-name state and the label and length rules, one character per step.
// ----------------------------------------------------------------------------
module dhv_name_check
	import dhv_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 step,
	input  logic                 last,
	input  char_class_t          char_class,
	input  logic [NameLenW-1:0]  max_name_length,
	input  logic [LabelLenW-1:0] max_label_length,
	output name_result_t         result
);

	logic                 error_q;
	logic [TotalW-1:0]    total_q;
	logic [LabelCntW-1:0] label_q;
	logic                 prev_hyphen_q;

	logic                 bad_char;
	logic                 err_step;
	logic                 err_final;
	logic [TotalW-1:0]    total_new;
	logic [LabelCntW-1:0] label_new;
	logic [LabelCntW-1:0] label_limit;

	always_comb begin
		label_limit = {1'b0, max_label_length};
		bad_char    = !(char_class.letter || char_class.digit ||
		                char_class.hyphen || char_class.dot);

		// The total saturates at 256, which is the only value with the top bit set.
		total_new = total_q[TotalW-1] ? total_q : total_q + 9'd1;

		if (char_class.dot) begin
			label_new = '0;
		end else if (label_q != LABEL_SAT) begin
			label_new = label_q + 7'd1;
		end else begin
			label_new = label_q;
		end

		err_step = error_q || bad_char;
		if (char_class.dot) begin
			err_step = err_step || (label_q == '0) || (label_q > label_limit) || prev_hyphen_q;
		end else begin
			err_step = err_step || ((label_q == '0) && !char_class.letter);
		end

		err_final = err_step || char_class.hyphen || char_class.dot ||
		            (label_new > label_limit) ||
		            (total_new > {1'b0, max_name_length});

		result.name_valid  = !err_final;
		result.name_length = total_new;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			error_q       <= 1'b0;
			total_q       <= '0;
			label_q       <= '0;
			prev_hyphen_q <= 1'b0;
		end else if (step) begin
			if (last) begin
				error_q       <= 1'b0;
				total_q       <= '0;
				label_q       <= '0;
				prev_hyphen_q <= 1'b0;
			end else begin
				error_q       <= err_step;
				total_q       <= total_new;
				label_q       <= label_new;
				prev_hyphen_q <= char_class.hyphen;
			end
		end
	end

endmodule

// ===== src/dhv_checker.sv =====
// ----------------------------------------------------------------------------
// dhv_checker
// Port-level checks on the host name checker's byte, result and configuration channels.
// ----------------------------------------------------------------------------
module dhv_checker
	import dhv_pkg::*;
(
	input logic              clk,
	input logic              arst_n,
	input logic              char_stall,
	input logic              result_valid,
	input logic              result_stall,
	input logic              name_valid,
	input logic [TotalW-1:0] name_length,
	input logic              cfg_ready
);

	// A stalled result stays offered.
	a_result_held: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid)
		else $error("result request dropped while stalled");

	// The byte channel only backs up behind a stalled result.
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		char_stall |-> (result_valid && result_stall))
		else $error("byte channel stalled without a stalled result");

	// Every name has at least one byte.
	a_length_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (name_length != '0))
		else $error("result with zero length");

	// The name limit is at most 255, so a valid name never reports 256.
	a_valid_length: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && name_valid |-> !name_length[TotalW-1])
		else $error("valid name longer than any allowed limit");

	// The configuration port never back-pressures.
	a_cfg_ready: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_ready)
		else $error("configuration port not ready");

endmodule

bind dns_hostname_validator dhv_checker u_dhv_checker (.*);
